/* hw/rtl/kcl_pkg.sv */
// ----------------------------------------------------------------------------
// kcl_pkg: shared types and constants of the keypad code lock
// Key codes, status and mode codes, counter widths and the step interface
// structs used between the lock datapath and its step logic.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Lengths of a code entry and of a reset entry, in keys
    localparam int CODE_LENGTH  = 4;
    localparam int RESET_LENGTH = 10;

    // Upper bound on the entry counter: the longer of the two entry lengths
    localparam int MAX_CNT = (CODE_LENGTH > RESET_LENGTH) ? CODE_LENGTH : RESET_LENGTH;
    localparam int CNT_W   = $clog2(MAX_CNT + 1);
    localparam int IDX_W   = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam int KEY_W   = 8;
    localparam int SHOWN_W = 4;

    // Key codes
    localparam logic [KEY_W-1:0] KEY_NONE   = 8'h00;
    localparam logic [KEY_W-1:0] KEY_CHANGE = 8'h5C;
    localparam logic [KEY_W-1:0] KEY_CLOSE  = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_RESET  = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_CANCEL = 8'h63;
    localparam logic [KEY_W-1:0] KEY_ZERO   = 8'h30;

    typedef enum logic [1:0] {
        MODE_MENU   = 2'd0,
        MODE_CHANGE = 2'd1,
        MODE_RESET  = 2'd2
    } mode_t;

    typedef enum logic [3:0] {
        ST_IGNORED    = 4'd0,
        ST_TAKEN      = 4'd1,
        ST_UNLOCKED   = 4'd2,
        ST_WRONG      = 4'd3,
        ST_CLOSED     = 4'd4,
        ST_CHG_START  = 4'd5,
        ST_SAVED      = 4'd6,
        ST_SAVE_FAIL  = 4'd7,
        ST_RST_START  = 4'd8,
        ST_RST_DONE   = 4'd9,
        ST_CANCELLED  = 4'd10,
        ST_MENU_IGNORE = 4'd11
    } status_t;

    typedef logic [CODE_LENGTH-1:0][KEY_W-1:0] code_t;

    // Control state of the lock
    typedef struct packed {
        logic             door_locked;
        mode_t            mode;
        logic [CNT_W-1:0] count;
        logic             mismatch;
    } lock_state_t;

    // Result of one key
    typedef struct packed {
        status_t            status;
        logic               door_closed;
        logic               beep;
        logic [SHOWN_W-1:0] shown;
    } lock_result_t;

    // Storage updates requested by one key
    typedef struct packed {
        logic             buf_we;
        logic [IDX_W-1:0] buf_idx;
        logic             load_new;
        logic             load_zero;
    } lock_store_t;

endpackage

/* hw/rtl/kcl_step.sv */
// ----------------------------------------------------------------------------
// kcl_step: next-state logic of the keypad code lock
// Works out, for one key, the next control state, the result beat and the
// password storage updates.
// ----------------------------------------------------------------------------
module kcl_step
    import kcl_pkg::*;
(
    input  logic [KEY_W-1:0] key,
    input  lock_state_t      cur,
    input  code_t            stored_code,
    output lock_state_t      nxt,
    output lock_result_t     res,
    output lock_store_t      store
);

    logic             in_entry;
    logic             mism;
    logic [CNT_W-1:0] cnt_inc;
    logic [31:0]      cnt_wide;
    logic             below_code;

    assign in_entry   = cur.door_locked || (cur.mode == MODE_CHANGE) || (cur.mode == MODE_RESET);
    assign cnt_inc    = cur.count + CNT_W'(1);
    assign cnt_wide   = 32'(cnt_inc);
    assign below_code = (32'(cur.count) < CODE_LENGTH);

    // Decode one key against the current entry
    always_comb
    begin
        nxt             = cur;
        res.status      = ST_IGNORED;
        res.beep        = 1'b0;
        res.shown       = '0;
        store.buf_we    = 1'b0;
        store.buf_idx   = cur.count[IDX_W-1:0];
        store.load_new  = 1'b0;
        store.load_zero = 1'b0;
        mism            = cur.mismatch;

        if (key == KEY_NONE)
        begin
            res.shown = 4'(32'(cur.count));
        end
        else if (key == KEY_CANCEL && in_entry)
        begin
            nxt.mode     = MODE_MENU;
            nxt.count    = '0;
            nxt.mismatch = 1'b0;
            res.status   = ST_CANCELLED;
        end
        else if (cur.mode == MODE_CHANGE)
        begin
            res.beep = 1'b1;
            if (below_code)
            begin
                store.buf_we = 1'b1;
                nxt.count    = cnt_inc;
                res.status   = ST_TAKEN;
                res.shown    = cnt_wide[SHOWN_W-1:0];
            end
            else
            begin
                res.shown = SHOWN_W'(CODE_LENGTH + 1);
                if (key == KEY_CHANGE)
                begin
                    store.load_new = 1'b1;
                    res.status     = ST_SAVED;
                end
                else
                begin
                    res.status = ST_SAVE_FAIL;
                end
                nxt.mode     = MODE_MENU;
                nxt.count    = '0;
                nxt.mismatch = 1'b0;
            end
        end
        else if (cur.mode == MODE_RESET)
        begin
            res.beep  = 1'b1;
            mism      = cur.mismatch || (key != KEY_ZERO);
            res.shown = cnt_wide[SHOWN_W-1:0];
            if (cnt_wide >= 32'(RESET_LENGTH))
            begin
                if (!mism)
                begin
                    store.load_zero = 1'b1;
                    res.status      = ST_RST_DONE;
                end
                else
                begin
                    res.status = ST_WRONG;
                end
                nxt.mode     = MODE_MENU;
                nxt.count    = '0;
                nxt.mismatch = 1'b0;
            end
            else
            begin
                nxt.count    = cnt_inc;
                nxt.mismatch = mism;
                res.status   = ST_TAKEN;
            end
        end
        else if (cur.door_locked)
        begin
            res.beep = 1'b1;
            if (below_code && key != stored_code[cur.count[IDX_W-1:0]])
            begin
                mism = 1'b1;
            end
            res.shown = cnt_wide[SHOWN_W-1:0];
            if (cnt_wide >= 32'(CODE_LENGTH))
            begin
                if (!mism)
                begin
                    nxt.door_locked = 1'b0;
                    res.status      = ST_UNLOCKED;
                end
                else
                begin
                    res.status = ST_WRONG;
                end
                nxt.mode     = MODE_MENU;
                nxt.count    = '0;
                nxt.mismatch = 1'b0;
            end
            else
            begin
                nxt.count    = cnt_inc;
                nxt.mismatch = mism;
                res.status   = ST_TAKEN;
            end
        end
        else
        begin
            // Open menu: only the three menu keys act
            nxt.mode     = MODE_MENU;
            nxt.count    = '0;
            nxt.mismatch = 1'b0;
            case (key)
                KEY_CLOSE:
                begin
                    nxt.door_locked = 1'b1;
                    res.status      = ST_CLOSED;
                    res.beep        = 1'b1;
                end
                KEY_CHANGE:
                begin
                    nxt.mode   = MODE_CHANGE;
                    res.status = ST_CHG_START;
                    res.beep   = 1'b1;
                end
                KEY_RESET:
                begin
                    nxt.mode   = MODE_RESET;
                    res.status = ST_RST_START;
                    res.beep   = 1'b1;
                end
                default:
                begin
                    res.status = ST_MENU_IGNORE;
                end
            endcase
        end

        res.door_closed = nxt.door_locked;
    end

endmodule

/* hw/rtl/keypad_code_lock.sv */
// ----------------------------------------------------------------------------
// keypad_code_lock: keypad driven door lock with password change and reset
// Takes one key code per beat, keeps the password and door state, and gives
// one status beat per key.
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake            payload
//   key       in         in_valid / in_stall  key_code[7:0]
//   result    out        out_valid/ out_stall status[3:0], door_closed, beep,
//                                             keys_entered[3:0]
//
// A key beat lands in the input register, is decoded by the combinational
// step logic and its result is written to the output register: the key
// passes the input register and then the output register, one key per cycle
// sustained while out_stall stays low.
// The input register refills in the same cycle the output register drains,
// so throughput is set only by the out_stall of the consumer.
// Reset clears the door to open, the password to all '0' and any entry.
// A stalled result holds its payload and backs up into in_stall.
// ----------------------------------------------------------------------------
module keypad_code_lock
    import kcl_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [KEY_W-1:0]   key_code,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [3:0]         status,
    output logic               door_closed,
    output logic               beep,
    output logic [SHOWN_W-1:0] keys_entered
);

    logic             in_valid_reg;
    logic [KEY_W-1:0] key_reg;
    lock_state_t      state_reg;
    code_t            stored_code_reg;
    code_t            new_code_reg;
    logic             out_valid_reg;
    lock_result_t     result_reg;

    lock_state_t      state_next;
    lock_result_t     result_next;
    lock_store_t      store;
    logic             advance;
    logic             in_accept;

    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    kcl_step u_step
    (
        .key         (key_reg),
        .cur         (state_reg),
        .stored_code (stored_code_reg),
        .nxt         (state_next),
        .res         (result_next),
        .store       (store)
    );

    // Hold the input beat until the step logic takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            key_reg <= key_code;
        end
    end

    // Advance the lock state and the password
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.door_locked <= 1'b0;
            state_reg.mode        <= MODE_MENU;
            state_reg.count       <= '0;
            state_reg.mismatch    <= 1'b0;
            stored_code_reg       <= {CODE_LENGTH{KEY_ZERO}};
        end
        else if (advance)
        begin
            state_reg <= state_next;
            if (store.load_new)
            begin
                stored_code_reg <= new_code_reg;
            end
            else if (store.load_zero)
            begin
                stored_code_reg <= {CODE_LENGTH{KEY_ZERO}};
            end
        end
    end

    // Collect the keys of a new password
    always_ff @(posedge clk)
    begin
        if (advance && store.buf_we)
        begin
            new_code_reg[store.buf_idx] <= key_reg;
        end
    end

    // Hold the result beat until the consumer takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = result_reg.status;
    assign door_closed  = result_reg.door_closed;
    assign beep         = result_reg.beep;
    assign keys_entered = result_reg.shown;

    // A locked door only ever runs a code entry
    a_locked_menu: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.door_locked |-> (state_reg.mode == MODE_MENU))
        else $error("door locked during a change or reset entry");

    // The entry counter never passes the longest entry
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(state_reg.count) <= MAX_CNT)
        else $error("entry counter out of range");

    // A mismatch is only remembered inside a code or reset entry
    a_mismatch_ctx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.mismatch |-> (state_reg.door_locked || state_reg.mode == MODE_RESET))
        else $error("mismatch flag set outside an entry");

    // The result reports the door state left by its key
    a_door_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (result_reg.door_closed == state_reg.door_locked))
        else $error("door_closed disagrees with the door state");

    // Stall the key channel only while a key waits in the input register
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("key channel stalled without a waiting result");

endmodule
